/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Clocked next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/core/drt_pkg.sv */
package drt_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam logic [15:0] ONE_Q15   = 16'd32768;

  typedef enum logic [1:0] {
    FUNC_REMEMBER = 2'd0,
    FUNC_ELAPSE   = 2'd1,
    FUNC_FORGET   = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_DECAY_RATE  = 2'd0,
    REG_FORGET_THR  = 2'd1,
    REG_ST_LIMIT    = 2'd2,
    REG_LT_THR      = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MRD,
    ST_MCHK,
    ST_APPEND,
    ST_WRD,
    ST_WCHK,
    ST_EVRD,
    ST_EVMOV,
    ST_CRD,
    ST_CCHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] source;
    logic [15:0] kind;
    logic [15:0] importance;
    logic [15:0] confidence;
    logic [15:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic       matched;
    logic       evicted;
    logic       refused;
    logic [5:0] dropped_count;
    logic [5:0] record_count;
  } out_item_t;

  // Saturate a Q1.15 value to 1.0
  function automatic logic [15:0] sat_q15(input logic [15:0] v);
    sat_q15 = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

/* rtl/core/decaying_record_table.sv */
// Decaying record table.
// Input channel in_valid/in_ready carries one in_item_t item: remember,
// elapse, forget or none. Each item produces exactly one out_item_t item on
// out_valid/out_ready with flags, dropped count and record count.
// Records live in one table walked by a small sequencer; each slot is read
// into a register in one state and checked in the next. Elapse and forget
// walk every held record, then load the result. Remember searches for a
// merge (stopping when it hits a record), then appends, walks the records
// to find the weakest short-term one, decides eviction, closes the gap and
// loads the result; a hit or a full table loads the result at once.
// in_ready is high only while idle, from the cycle after each result is
// loaded, so a new item is taken only after the last one's result is loaded.
// The result register holds until out_ready; a stalled receiver keeps the
// next item's sequencer in its last step and so stalls the input.
// Reset clears the record count and registers (decay 0, forget 0,
// short-term limit 8, long-term threshold 1.0); no clearing pass is needed.
// Configuration writes go through the cfg_ APB port; the user must make them
// only while idle, as the block itself does not enforce it.
module decaying_record_table #(
  parameter int unsigned DEPTH = drt_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  drt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output drt_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > 6) ? CW : 6;

  typedef struct packed {
    logic [63:0] source;
    logic [15:0] kind;
    logic [15:0] importance;
    logic [15:0] strength;
    logic        lt_mark;
  } rec_t;

  // Config registers
  logic [15:0] decay_rate_r, forget_thr_r, lt_thr_r;
  logic [5:0]  st_limit_r;
  logic        cfg_wr;
  drt_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = drt_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_rate_r <= '0;
      forget_thr_r <= '0;
      st_limit_r   <= 6'd8;
      lt_thr_r     <= drt_pkg::ONE_Q15;
    end else if (cfg_wr) begin
      case (cfg_idx)
        drt_pkg::REG_DECAY_RATE: decay_rate_r <= cfg_pwdata[15:0];
        drt_pkg::REG_FORGET_THR: forget_thr_r <= cfg_pwdata[15:0];
        drt_pkg::REG_ST_LIMIT:   st_limit_r   <= cfg_pwdata[5:0];
        drt_pkg::REG_LT_THR:     lt_thr_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      drt_pkg::REG_DECAY_RATE: cfg_prdata = {16'd0, decay_rate_r};
      drt_pkg::REG_FORGET_THR: cfg_prdata = {16'd0, forget_thr_r};
      drt_pkg::REG_ST_LIMIT:   cfg_prdata = {26'd0, st_limit_r};
      drt_pkg::REG_LT_THR:     cfg_prdata = {16'd0, lt_thr_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // Record memory, one write and one read port
  rec_t        mem [DEPTH];
  rec_t        rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        wr_en;
  rec_t        wr_rec;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_rec;
    rd_q <= mem[rd_addr];
  end

  // Sequencer state
  drt_pkg::state_t state_r, state_nxt;
  drt_pkg::in_item_t item_r, item_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] idx_r, idx_nxt;      // read pointer
  logic [CW-1:0] w_r, w_nxt;          // write pointer / weakest index
  logic [CW-1:0] st_r, st_nxt;        // short-term count
  logic [15:0]   weak_s_r, weak_s_nxt;
  logic          have_r, have_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [5:0]    drop_r, drop_nxt;
  logic          matched_r, matched_nxt, evicted_r, evicted_nxt, refused_r, refused_nxt;
  logic          out_valid_r, out_valid_nxt;
  drt_pkg::out_item_t out_r, out_nxt;

  logic [15:0] imp_s, conf_s;
  logic [21:0] loss_s, loss_l_r, loss_l_nxt;
  logic [42:0] recip;
  logic [22:0] loss;
  logic signed [23:0] diff;
  logic        id_hit;
  logic        evict;
  rec_t        merged;

  assign imp_s  = drt_pkg::sat_q15(item_r.importance);
  assign conf_s = drt_pkg::sat_q15(item_r.confidence);
  assign loss_s = prod_r[31:10];
  // Long-term loss: (prod >> 11) / 5 by reciprocal, exact below 2^22
  assign recip      = {22'd0, prod_r[31:11]} * 43'd3355444;
  assign loss_l_nxt = {3'd0, recip[42:24]};
  assign loss   = rd_q.lt_mark ? {1'b0, loss_l_r} : {1'b0, loss_s};
  assign diff   = $signed({8'd0, rd_q.strength}) - $signed({1'b0, loss});
  assign id_hit = (rd_q.source == item_r.source) && (rd_q.kind == item_r.kind);
  assign evict  = have_r && (LW'(st_r) > LW'(st_limit_r));

  always_comb begin
    merged = rd_q;
    if (imp_s > rd_q.importance) merged.importance = imp_s;
    if (conf_s > rd_q.strength)  merged.strength   = conf_s;
    if (merged.importance >= lt_thr_r) merged.lt_mark = 1'b1;
  end

  assign in_ready  = (state_r == drt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      drt_pkg::ST_IDLE:
        if (in_valid) begin
          case (drt_pkg::func_t'(in_data.func))
            drt_pkg::FUNC_REMEMBER: state_nxt = drt_pkg::ST_MRD;
            drt_pkg::FUNC_ELAPSE,
            drt_pkg::FUNC_FORGET:   state_nxt = drt_pkg::ST_CRD;
            default:                state_nxt = drt_pkg::ST_DONE;
          endcase
        end
      drt_pkg::ST_MRD:
        state_nxt = (item_r.source == '0 || idx_r >= held_r) ?
                    drt_pkg::ST_APPEND : drt_pkg::ST_MCHK;
      drt_pkg::ST_MCHK:
        state_nxt = id_hit ? drt_pkg::ST_DONE : drt_pkg::ST_MRD;
      drt_pkg::ST_APPEND:
        state_nxt = (held_r >= CW'(DEPTH)) ? drt_pkg::ST_DONE : drt_pkg::ST_WRD;
      drt_pkg::ST_WRD:
        state_nxt = (idx_r >= held_r) ? drt_pkg::ST_EVRD : drt_pkg::ST_WCHK;
      drt_pkg::ST_WCHK:  state_nxt = drt_pkg::ST_WRD;
      // Shift only when the evicted slot is not the last one
      drt_pkg::ST_EVRD:
        state_nxt = (evict && (w_r + 1'b1 < held_r)) ? drt_pkg::ST_EVMOV : drt_pkg::ST_DONE;
      drt_pkg::ST_EVMOV:
        state_nxt = (idx_r + 1'b1 >= held_r) ? drt_pkg::ST_DONE : drt_pkg::ST_EVMOV;
      drt_pkg::ST_CRD:
        state_nxt = (idx_r >= held_r) ? drt_pkg::ST_DONE : drt_pkg::ST_CCHK;
      drt_pkg::ST_CCHK:  state_nxt = drt_pkg::ST_CRD;
      drt_pkg::ST_DONE:
        state_nxt = (!out_valid_r || out_ready) ? drt_pkg::ST_IDLE : drt_pkg::ST_DONE;
      default: state_nxt = drt_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    item_nxt    = item_r;
    held_nxt    = held_r;
    idx_nxt     = idx_r;
    w_nxt       = w_r;
    st_nxt      = st_r;
    weak_s_nxt  = weak_s_r;
    have_nxt    = have_r;
    prod_nxt    = prod_r;
    drop_nxt    = drop_r;
    matched_nxt = matched_r;
    evicted_nxt = evicted_r;
    refused_nxt = refused_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt     = out_r;
    rd_addr     = idx_r[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = w_r[AW-1:0];
    wr_rec      = rd_q;
    case (state_r)
      drt_pkg::ST_IDLE:
        if (in_valid) begin
          item_nxt = in_data;
          idx_nxt = '0; w_nxt = '0; st_nxt = '0; have_nxt = 1'b0;
          drop_nxt = '0; matched_nxt = 1'b0; evicted_nxt = 1'b0; refused_nxt = 1'b0;
          prod_nxt = {16'd0, decay_rate_r} * {16'd0, in_data.elapsed};
          rd_addr  = '0;
        end
      drt_pkg::ST_MRD: ;
      drt_pkg::ST_MCHK: begin
        if (id_hit) begin
          wr_en = 1'b1; wr_addr = idx_r[AW-1:0]; wr_rec = merged;
          matched_nxt = 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        rd_addr = AW'(idx_r + 1'b1);
      end
      drt_pkg::ST_APPEND: begin
        if (held_r >= CW'(DEPTH)) begin
          refused_nxt = 1'b1;
        end else begin
          wr_en = 1'b1; wr_addr = held_r[AW-1:0];
          wr_rec.source = item_r.source; wr_rec.kind = item_r.kind;
          wr_rec.importance = imp_s; wr_rec.strength = conf_s;
          wr_rec.lt_mark = imp_s >= lt_thr_r;
          held_nxt = held_r + 1'b1;
        end
        idx_nxt = '0;
        rd_addr = '0;
      end
      drt_pkg::ST_WRD: idx_nxt = idx_r;
      drt_pkg::ST_WCHK: begin
        if (!rd_q.lt_mark) begin
          st_nxt = st_r + 1'b1;
          if (!have_r || rd_q.strength < weak_s_r) begin
            w_nxt = idx_r; weak_s_nxt = rd_q.strength; have_nxt = 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
        rd_addr = AW'(idx_r + 1'b1);
      end
      drt_pkg::ST_EVRD: begin
        idx_nxt = w_r;
        rd_addr = AW'(w_r + 1'b1);
        if (evict) begin
          evicted_nxt = 1'b1;
          held_nxt = held_r - 1'b1;
        end
      end
      drt_pkg::ST_EVMOV: begin
        // rd_q holds slot idx+1; shift it down
        wr_en = 1'b1; wr_addr = idx_r[AW-1:0]; wr_rec = rd_q;
        idx_nxt = idx_r + 1'b1;
        rd_addr = AW'(idx_r + 2'd2);
      end
      drt_pkg::ST_CRD: idx_nxt = idx_r;
      drt_pkg::ST_CCHK: begin
        if ((item_r.func == drt_pkg::FUNC_ELAPSE) ?
            (diff < $signed({8'd0, forget_thr_r})) : id_hit) begin
          drop_nxt = drop_r + 1'b1;
        end else begin
          wr_en = 1'b1; wr_addr = w_r[AW-1:0]; wr_rec = rd_q;
          if (item_r.func == drt_pkg::FUNC_ELAPSE) wr_rec.strength = diff[15:0];
          w_nxt = w_r + 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        rd_addr = AW'(idx_r + 1'b1);
      end
      drt_pkg::ST_DONE:
        if (!out_valid_r || out_ready) begin
          if (item_r.func == drt_pkg::FUNC_ELAPSE || item_r.func == drt_pkg::FUNC_FORGET)
            held_nxt = w_r;
          out_valid_nxt = 1'b1;
          out_nxt.matched = (item_r.func == drt_pkg::FUNC_FORGET) ? (drop_r != '0)
                            : matched_r;
          out_nxt.evicted = evicted_r;
          out_nxt.refused = refused_r;
          out_nxt.dropped_count = drop_r;
          out_nxt.record_count = 6'((item_r.func == drt_pkg::FUNC_ELAPSE ||
                                     item_r.func == drt_pkg::FUNC_FORGET) ? w_r : held_r);
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drt_pkg::ST_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    idx_r     <= idx_nxt;
    w_r       <= w_nxt;
    st_r      <= st_nxt;
    weak_s_r  <= weak_s_nxt;
    have_r    <= have_nxt;
    prod_r    <= prod_nxt;
    loss_l_r  <= loss_l_nxt;
    drop_r    <= drop_nxt;
    matched_r <= matched_nxt;
    evicted_r <= evicted_nxt;
    refused_r <= refused_nxt;
    out_r     <= out_nxt;
  end

endmodule

/* rtl/core/drt_checker.sv */
`include "assert_macros.svh"
module drt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input drt_pkg::out_item_t out_data
);
  // A result never claims both an eviction and a refusal
  `ASSERT_IMPL(a_flags, clk, rst_n, out_valid, !(out_data.refused && out_data.evicted), "refused and evicted together")
  // A taken item keeps the block busy in the next cycle
  `ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while busy")
  // Record count never exceeds 32, the default table depth
  `ASSERT_IMPL(a_count, clk, rst_n, out_valid, out_data.record_count <= 6'd32, "record count too large")
  // Stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
endmodule

bind decaying_record_table drt_checker u_drt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
